// ===== hdl/isodur_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isodur_pkg: shared types and constants for the ISO 8601 duration parser
// Character codes, component ranks, minute weights and status codes.
// ----------------------------------------------------------------------------
package isodur_pkg;

  // Width of the digit accumulator; a component must fit in this many bits.
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned COMP_W     = 32;
  localparam int unsigned NUM_COMP   = 7;
  localparam int unsigned RANK_W     = 3;

  typedef logic [7:0]        char_t;
  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [COMP_W-1:0] comp_t;

  localparam char_t CH_0 = 8'h30;
  localparam char_t CH_9 = 8'h39;
  localparam char_t CH_P = 8'h50;
  localparam char_t CH_T = 8'h54;
  localparam char_t CH_Y = 8'h59;
  localparam char_t CH_M = 8'h4D;
  localparam char_t CH_W = 8'h57;
  localparam char_t CH_D = 8'h44;
  localparam char_t CH_H = 8'h48;
  localparam char_t CH_S = 8'h53;

  localparam rank_t RANK_YEAR  = 3'd0;
  localparam rank_t RANK_MONTH = 3'd1;
  localparam rank_t RANK_WEEK  = 3'd2;
  localparam rank_t RANK_DAY   = 3'd3;
  localparam rank_t RANK_HOUR  = 3'd4;
  localparam rank_t RANK_MIN   = 3'd5;
  localparam rank_t RANK_SEC   = 3'd6;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_P    = 2'd1,
    ST_OVERRUN = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_SEEK = 4'b0001,
    PH_DATE = 4'b0010,
    PH_TIME = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  // Minutes per unit of each component; seconds do not count.
  function automatic comp_t rank_weight(input rank_t rank);
    comp_t w;
    w = '0;
    unique case (rank)
      RANK_YEAR:  w = 32'd525960;
      RANK_MONTH: w = 32'd43800;
      RANK_WEEK:  w = 32'd10080;
      RANK_DAY:   w = 32'd1440;
      RANK_HOUR:  w = 32'd60;
      RANK_MIN:   w = 32'd1;
      default:    w = 32'd0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/iso_duration_to_minutes.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iso_duration_to_minutes: streaming ISO 8601 duration parser
// Parses one character per transaction and returns the seven components and
// a weighted total in minutes when the character marked tlast arrives.
// ----------------------------------------------------------------------------
// The block takes one character in every clock cycle as long as the output
// side keeps up; in_tready drops only when a result is held and out_tready is
// low, so a waiting result stalls every following character. Each character
// is parsed in the cycle it is accepted: the parse state and a running minute
// total are updated by one pass of logic whose longest path is the weight
// multiply and add on the running total. The result is registered and appears
// on the output in the cycle after the tlast character is accepted; the parser is
// back in its reset state for the next string in that same cycle.
module iso_duration_to_minutes (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [7:0]    in_tdata,   // [7:0] ch
  input  wire logic          in_tlast,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [255:0]       out_tdata,  // years, months, weeks, days, hours,
                                         // mins, secs, total_minutes (32 each)
  output logic [1:0]         out_tuser   // [1:0] status
);
  import isodur_pkg::*;

  localparam int unsigned ACC_W = VALUE_BITS + 4;

  phase_t                  phase_r, phase_nxt;
  rank_t                   next_rank_r, next_rank_nxt;
  logic [VALUE_BITS-1:0]   accum_r, accum_nxt;
  logic                    accum_over_r, accum_over_nxt;
  logic                    pending_r, pending_nxt;
  comp_t                   comp_r [NUM_COMP];
  comp_t                   comp_nxt [NUM_COMP];
  logic                    over_seen_r, over_seen_nxt;
  comp_t                   total_r, total_nxt;

  logic                    out_valid_r;
  logic [255:0]            out_data_r, out_data_nxt;
  status_t                 out_status_r, out_status_nxt;

  logic                    in_fire;
  char_t                   ch;
  logic                    is_digit;
  logic [ACC_W-1:0]        acc_ext;
  logic [ACC_W-1:0]        acc_prod;
  logic                    rank_ok;
  rank_t                   rank;
  comp_t                   accum_low;
  comp_t                   term;

  assign ch        = in_tdata;
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign is_digit  = (ch >= CH_0) && (ch <= CH_9);

  // accum*10 + digit, with headroom to see it pass the component limit.
  assign acc_ext   = ACC_W'(accum_r);
  assign acc_prod  = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(ch[3:0]);
  assign accum_low = COMP_W'(accum_r);
  assign term      = accum_low * rank_weight(rank);

  // Designator decode; the same letter M means months or minutes by part.
  always_comb begin
    rank_ok = 1'b0;
    rank    = RANK_YEAR;
    if (phase_r == PH_DATE) begin
      priority if (ch == CH_Y) begin
        rank_ok = 1'b1; rank = RANK_YEAR;
      end else if (ch == CH_M) begin
        rank_ok = 1'b1; rank = RANK_MONTH;
      end else if (ch == CH_W) begin
        rank_ok = 1'b1; rank = RANK_WEEK;
      end else if (ch == CH_D) begin
        rank_ok = 1'b1; rank = RANK_DAY;
      end else begin
        rank_ok = 1'b0;
      end
    end else if (phase_r == PH_TIME) begin
      priority if (ch == CH_H) begin
        rank_ok = 1'b1; rank = RANK_HOUR;
      end else if (ch == CH_M) begin
        rank_ok = 1'b1; rank = RANK_MIN;
      end else if (ch == CH_S) begin
        rank_ok = 1'b1; rank = RANK_SEC;
      end else begin
        rank_ok = 1'b0;
      end
    end
  end

  // Parse step for one character.
  always_comb begin
    phase_nxt      = phase_r;
    next_rank_nxt  = next_rank_r;
    accum_nxt      = accum_r;
    accum_over_nxt = accum_over_r;
    pending_nxt    = pending_r;
    over_seen_nxt  = over_seen_r;
    total_nxt      = total_r;
    for (int i = 0; i < NUM_COMP; i++) begin
      comp_nxt[i] = comp_r[i];
    end

    unique case (phase_r)
      PH_SEEK: begin
        if (ch == CH_P) begin
          phase_nxt = PH_DATE;
        end
      end
      PH_DONE: begin
      end
      default: begin
        priority if (is_digit) begin
          if (accum_over_r || (acc_prod[ACC_W-1:VALUE_BITS] != '0)) begin
            accum_over_nxt = 1'b1;
          end else begin
            accum_nxt = acc_prod[VALUE_BITS-1:0];
          end
          pending_nxt = 1'b1;
        end else if (ch == CH_T) begin
          if ((phase_r == PH_DATE) && !pending_r) begin
            phase_nxt     = PH_TIME;
            next_rank_nxt = RANK_HOUR;
          end else begin
            phase_nxt      = PH_DONE;
            pending_nxt    = 1'b0;
            accum_nxt      = '0;
            accum_over_nxt = 1'b0;
          end
        end else if (!rank_ok || !pending_r || (rank < next_rank_r)) begin
          phase_nxt      = PH_DONE;
          pending_nxt    = 1'b0;
          accum_nxt      = '0;
          accum_over_nxt = 1'b0;
        end else begin
          // Each rank is taken at most once, so the total can run along.
          comp_nxt[rank] = accum_low;
          over_seen_nxt  = over_seen_r || accum_over_r;
          next_rank_nxt  = rank + RANK_W'(1);
          pending_nxt    = 1'b0;
          accum_nxt      = '0;
          accum_over_nxt = 1'b0;
          total_nxt      = total_r + term;
        end
      end
    endcase
  end

  // Result built from the state after this character.
  always_comb begin
    out_data_nxt   = '0;
    out_status_nxt = ST_OK;
    priority if (phase_nxt == PH_SEEK) begin
      out_status_nxt = ST_NO_P;
    end else if (over_seen_nxt) begin
      out_status_nxt = ST_OVERRUN;
    end else begin
      for (int i = 0; i < NUM_COMP; i++) begin
        out_data_nxt[i*COMP_W +: COMP_W] = comp_nxt[i];
      end
      out_data_nxt[NUM_COMP*COMP_W +: COMP_W] = total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SEEK;
      next_rank_r  <= RANK_YEAR;
      accum_r      <= '0;
      accum_over_r <= 1'b0;
      pending_r    <= 1'b0;
      over_seen_r  <= 1'b0;
      total_r      <= '0;
      for (int i = 0; i < NUM_COMP; i++) begin
        comp_r[i] <= '0;
      end
    end else if (in_fire) begin
      if (in_tlast) begin
        // The string is finished: start over for the next one.
        phase_r      <= PH_SEEK;
        next_rank_r  <= RANK_YEAR;
        accum_r      <= '0;
        accum_over_r <= 1'b0;
        pending_r    <= 1'b0;
        over_seen_r  <= 1'b0;
        total_r      <= '0;
        for (int i = 0; i < NUM_COMP; i++) begin
          comp_r[i] <= '0;
        end
      end else begin
        phase_r      <= phase_nxt;
        next_rank_r  <= next_rank_nxt;
        accum_r      <= accum_nxt;
        accum_over_r <= accum_over_nxt;
        pending_r    <= pending_nxt;
        over_seen_r  <= over_seen_nxt;
        total_r      <= total_nxt;
        for (int i = 0; i < NUM_COMP; i++) begin
          comp_r[i] <= comp_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_tlast) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_tlast) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule
`default_nettype wire
